[sv/grid_nearest_obstacle_search_core_assert.svh]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: assertion macros
// Implication checks on the rising clock edge, off while in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_NEAREST_OBSTACLE_SEARCH_CORE_ASSERT_SVH
`define GRID_NEAREST_OBSTACLE_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GNOS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define GNOS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GNOS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define GNOS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[sv/gnos_pkg.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: package
// Shared types, register indexes, status codes and defaults.
// ---------------------------------------------------------------------------
`default_nettype none
package gnos_pkg;
  localparam int MAP_DIM_DEF    = 256;
  localparam int MAX_RADIUS_DEF = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_SIDE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Y      = 3'd4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STATUS_FOUND   = 2'd0;
  localparam logic [1:0] STATUS_NONE    = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [23:0]        DIST_MAX = 24'hFFFFFF;
  localparam logic signed [23:0] S24_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN  = 24'sh800000;

  localparam logic [15:0] PIXEL_SIZE_RST = 16'd256;
  localparam logic [8:0]  MAP_SIDE_RST   = 9'd256;
  localparam logic [6:0]  RADIUS_RST     = 7'd32;

  typedef struct packed {
    logic               mode;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
    logic               is_obstacle;
    logic signed [23:0] query_x;
    logic signed [23:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [23:0]        distance;
    logic signed [23:0] obstacle_x;
    logic signed [23:0] obstacle_y;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic map_write;
    logic q_load;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic scan_init;
    logic scan_step;
    logic sqrt_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic outside;
    logic scan_last;
    logic pipe_busy;
    logic found;
    logic sqrt_done;
    logic out_free;
  } dp_sts_t;
endpackage
`default_nettype wire

[sv/gnos_stream_if.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: stream interface
// Valid/ready channel; one transfer per edge with both high.
// ---------------------------------------------------------------------------
`default_nettype none
interface gnos_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/gnos_div.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: iterative divider
// Signed by unsigned, truncating toward zero, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module gnos_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic [NUM_W-1:0]        q_mag,
  output logic                    q_neg
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, neg_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg_r <= num[NUM_W-1];
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign done  = done_r;
  assign q_mag = quo_r;
  assign q_neg = neg_r;
endmodule
`default_nettype wire

[sv/gnos_isqrt.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: iterative square root
// Truncated integer root, one result bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module gnos_isqrt #(
  parameter int IN_W = 53
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [IN_W-1:0]         radicand,
  output logic                    done,
  output logic [(IN_W+1)/2-1:0]   root
);
  localparam int SQ_W  = (IN_W + 1) / 2;
  localparam int CNT_W = $clog2(SQ_W + 1);

  logic [2*SQ_W-1:0] rad_r;
  logic [SQ_W-1:0]   root_r;
  logic [SQ_W:0]     rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [SQ_W+2:0]   remw, trial, rem_nxt;
  logic              ge;

  always_comb begin
    remw    = {rem_r, rad_r[2*SQ_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = remw >= trial;
    rem_nxt = ge ? (remw - trial) : remw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(SQ_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= (2*SQ_W)'(radicand);
      root_r <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*SQ_W-3:0], 2'b00};
      root_r <= {root_r[SQ_W-2:0], ge};
      rem_r  <= rem_nxt[SQ_W:0];
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

[sv/gnos_ctrl.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: controller
// Sequences map clear, writes, index division, window scan and result.
// ---------------------------------------------------------------------------
`default_nettype none
module gnos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  gnos_pkg::dp_sts_t   sts,
  output gnos_pkg::ctrl_cmd_t cmd
);
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_XSTART = 4'd2;
  localparam logic [3:0] ST_XWAIT  = 4'd3;
  localparam logic [3:0] ST_YSTART = 4'd4;
  localparam logic [3:0] ST_YWAIT  = 4'd5;
  localparam logic [3:0] ST_CHECK  = 4'd6;
  localparam logic [3:0] ST_SCAN   = 4'd7;
  localparam logic [3:0] ST_DRAIN  = 4'd8;
  localparam logic [3:0] ST_ROOT   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == gnos_pkg::MODE_QUERY) begin
            cmd.q_load = 1'b1;
            state_nxt  = ST_XSTART;
          end else begin
            cmd.map_write = 1'b1;
          end
        end
      end
      ST_XSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (sts.div_done) begin
          cmd.cap_x = 1'b1;
          state_nxt = ST_YSTART;
        end
      end
      ST_YSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_nxt     = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (sts.div_done) begin
          cmd.cap_y = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.outside) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          if (sts.found) begin
            cmd.sqrt_start = 1'b1;
            state_nxt      = ST_ROOT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ROOT: begin
        if (sts.sqrt_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

[sv/gnos_datapath.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search: datapath
// Config registers, map store, scan pipeline, best tracking, result register.
// ---------------------------------------------------------------------------
`default_nettype none
module gnos_datapath #(
  parameter int MAP_DIM    = gnos_pkg::MAP_DIM_DEF,
  parameter int MAX_RADIUS = gnos_pkg::MAX_RADIUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gnos_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gnos_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  gnos_pkg::in_item_t                 in_item,
  input  gnos_pkg::ctrl_cmd_t                cmd,
  output gnos_pkg::dp_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gnos_pkg::out_item_t                out_item
);
  localparam int COL_W  = $clog2(MAP_DIM);
  localparam int SIDE_W = $clog2(MAP_DIM + 1);
  localparam int SW     = (SIDE_W > 9) ? SIDE_W : 9;
  localparam int DEPTH  = MAP_DIM * MAP_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int RW     = (RAD_W > 7) ? RAD_W : 7;
  localparam int SC_W   = $clog2(MAP_DIM + MAX_RADIUS) + 2;
  localparam int PROD_W = COL_W + 16;
  localparam int T_W    = ((PROD_W > 24) ? PROD_W : 24) + 2;
  localparam int AB_W   = T_W - 1;
  localparam int D2_W   = 2 * AB_W + 1;
  localparam int SQ_W   = (D2_W + 1) / 2;
  localparam int DW     = (SQ_W > 24) ? SQ_W : 24;
  localparam int NUM_W  = 25;

  // configuration
  logic [15:0]        ps_r;
  logic [8:0]         side_r;
  logic [6:0]         rad_r;
  logic signed [23:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= gnos_pkg::PIXEL_SIZE_RST;
      side_r <= gnos_pkg::MAP_SIDE_RST;
      rad_r  <= gnos_pkg::RADIUS_RST;
      cx_r   <= '0;
      cy_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gnos_pkg::REG_PIXEL_SIZE:    ps_r   <= cfg_wdata[15:0];
        gnos_pkg::REG_MAP_SIDE:      side_r <= cfg_wdata[8:0];
        gnos_pkg::REG_WINDOW_RADIUS: rad_r  <= cfg_wdata[6:0];
        gnos_pkg::REG_CORNER_X:      cx_r   <= cfg_wdata;
        gnos_pkg::REG_CORNER_Y:      cy_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [15:0]            ps_eff;
  logic [SW-1:0]          side_x, side_eff;
  logic [RW-1:0]          rad_x, rad_eff;
  logic signed [SC_W-1:0] side_s, rad_s;

  always_comb begin
    ps_eff   = (ps_r == 16'd0) ? 16'd1 : ps_r;
    side_x   = SW'(side_r);
    side_eff = (side_x > SW'(MAP_DIM)) ? SW'(MAP_DIM) : side_x;
    rad_x    = RW'(rad_r);
    rad_eff  = (rad_x > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : rad_x;
    side_s   = SC_W'(side_eff);
    rad_s    = SC_W'(rad_eff);
  end

  // query setup
  logic signed [NUM_W-1:0] offx_r, offy_r, div_num;
  logic [31:0]             ps2_r;
  logic                    div_done, q_neg;
  logic [NUM_W-1:0]        q_mag;
  logic signed [SC_W-1:0]  ix_r, iy_r, q_idx;
  logic                    outside_r, q_out;

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      offx_r <= NUM_W'(cx_r) - NUM_W'(in_item.query_x);
      offy_r <= NUM_W'(cy_r) - NUM_W'(in_item.query_y);
      ps2_r  <= 32'(ps_eff) * 32'(ps_eff);
    end
  end

  assign div_num = cmd.div_sel_y ? offy_r : -offx_r;

  gnos_div #(.NUM_W(NUM_W), .DEN_W(16)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (ps_eff),
    .done  (div_done),
    .q_mag (q_mag),
    .q_neg (q_neg)
  );

  always_comb begin
    q_idx = q_neg ? -SC_W'(q_mag) : SC_W'(q_mag);
    q_out = q_mag >= NUM_W'(side_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      ix_r      <= q_idx;
      outside_r <= q_out;
    end
    if (cmd.cap_y) begin
      iy_r      <= q_idx;
      outside_r <= outside_r | q_out;
    end
  end

  // window scan counters: column outer, row inner
  logic signed [SC_W-1:0] x_r, y_r, x_end, y_end;
  logic                   in_map, scan_last;

  always_comb begin
    x_end     = ix_r + rad_s;
    y_end     = iy_r + rad_s;
    scan_last = (x_r == x_end) && (y_r == y_end);
    in_map    = !x_r[SC_W-1] && (x_r < side_s) && !y_r[SC_W-1] && (y_r < side_s);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      x_r <= ix_r - rad_s;
      y_r <= iy_r - rad_s;
    end else if (cmd.scan_step) begin
      if (y_r == y_end) begin
        y_r <= iy_r - rad_s;
        x_r <= x_r + SC_W'(1);
      end else begin
        y_r <= y_r + SC_W'(1);
      end
    end
  end

  // map store
  logic              map_mem [DEPTH];
  logic [ADDR_W-1:0] clr_r, wr_addr, rd_addr;
  logic              wr_en, wr_bit, wr_ok;

  always_comb begin
    wr_ok   = (32'(in_item.pixel_col) < MAP_DIM) && (32'(in_item.pixel_row) < MAP_DIM);
    wr_en   = cmd.clr_step || (cmd.map_write && wr_ok);
    wr_bit  = cmd.clr_step ? 1'b0 : in_item.is_obstacle;
    wr_addr = cmd.clr_step ? clr_r :
              ADDR_W'(ADDR_W'(in_item.pixel_row) * ADDR_W'(MAP_DIM)
                      + ADDR_W'(in_item.pixel_col));
    rd_addr = ADDR_W'(ADDR_W'(y_r[COL_W-1:0]) * ADDR_W'(MAP_DIM)
                      + ADDR_W'(x_r[COL_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + ADDR_W'(1);
  end

  logic rd1_r;
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_bit;
    rd1_r <= map_mem[rd_addr];
  end

  // distance pipeline
  logic                   v1_r, v2_r, v3_r, v4_r;
  logic [COL_W-1:0]       x1_r, y1_r;
  logic [PROD_W-1:0]      px2_r, py2_r;
  logic signed [T_W-1:0]  tx3_r, ty3_r, tx4_r, ty4_r, dxs, dys;
  logic [AB_W-1:0]        dx3_r, dy3_r;
  logic [2*AB_W-1:0]      sx4_r, sy4_r;
  logic [D2_W-1:0]        d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_step && in_map;
      v2_r <= v1_r && rd1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    dxs = T_W'(offx_r) + T_W'(px2_r);
    dys = T_W'(offy_r) - T_W'(py2_r);
    d2  = D2_W'(sx4_r) + D2_W'(sy4_r);
  end

  always_ff @(posedge clk) begin
    x1_r  <= x_r[COL_W-1:0];
    y1_r  <= y_r[COL_W-1:0];
    px2_r <= PROD_W'(x1_r) * PROD_W'(ps_eff);
    py2_r <= PROD_W'(y1_r) * PROD_W'(ps_eff);
    tx3_r <= T_W'(cx_r) + T_W'(px2_r);
    ty3_r <= T_W'(cy_r) - T_W'(py2_r);
    dx3_r <= dxs[T_W-1] ? AB_W'(-dxs) : AB_W'(dxs);
    dy3_r <= dys[T_W-1] ? AB_W'(-dys) : AB_W'(dys);
    tx4_r <= tx3_r;
    ty4_r <= ty3_r;
    sx4_r <= (2*AB_W)'(dx3_r) * (2*AB_W)'(dx3_r);
    sy4_r <= (2*AB_W)'(dy3_r) * (2*AB_W)'(dy3_r);
  end

  // best so far; equal distance replaces, so the later pixel wins
  logic                  found_r;
  logic [D2_W-1:0]       best_d2_r;
  logic signed [T_W-1:0] best_tx_r, best_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.scan_init) begin
      found_r <= 1'b0;
    end else if (v4_r && (!found_r || d2 <= best_d2_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && (!found_r || d2 <= best_d2_r)) begin
      best_d2_r <= d2;
      best_tx_r <= tx4_r;
      best_ty_r <= ty4_r;
    end
  end

  logic            sqrt_done;
  logic [SQ_W-1:0] root;

  gnos_isqrt #(.IN_W(D2_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (best_d2_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // result formatting
  logic [DW-1:0]       root_x;
  logic [23:0]         dist_val;
  logic signed [23:0]  ox, oy;
  gnos_pkg::out_item_t res;

  always_comb begin
    root_x = DW'(root);
    if (best_d2_r < D2_W'(ps2_r))                   dist_val = 24'd0;
    else if (root_x > DW'(gnos_pkg::DIST_MAX))      dist_val = gnos_pkg::DIST_MAX;
    else                                            dist_val = root_x[23:0];
    if (best_tx_r > T_W'(gnos_pkg::S24_MAX))        ox = gnos_pkg::S24_MAX;
    else if (best_tx_r < T_W'(gnos_pkg::S24_MIN))   ox = gnos_pkg::S24_MIN;
    else                                            ox = best_tx_r[23:0];
    if (best_ty_r > T_W'(gnos_pkg::S24_MAX))        oy = gnos_pkg::S24_MAX;
    else if (best_ty_r < T_W'(gnos_pkg::S24_MIN))   oy = gnos_pkg::S24_MIN;
    else                                            oy = best_ty_r[23:0];

    if (outside_r) begin
      res.status     = gnos_pkg::STATUS_OUTSIDE;
      res.distance   = '0;
      res.obstacle_x = '0;
      res.obstacle_y = '0;
    end else if (!found_r) begin
      res.status     = gnos_pkg::STATUS_NONE;
      res.distance   = gnos_pkg::DIST_MAX;
      res.obstacle_x = '0;
      res.obstacle_y = '0;
    end else begin
      res.status     = gnos_pkg::STATUS_FOUND;
      res.distance   = dist_val;
      res.obstacle_x = ox;
      res.obstacle_y = oy;
    end
  end

  logic                out_valid_r;
  gnos_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (cmd.out_load)           out_valid_r <= 1'b1;
    else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  always_comb begin
    sts.clr_last  = clr_r == ADDR_W'(DEPTH - 1);
    sts.div_done  = div_done;
    sts.outside   = outside_r;
    sts.scan_last = scan_last;
    sts.pipe_busy = v1_r || v2_r || v3_r || v4_r;
    sts.found     = found_r;
    sts.sqrt_done = sqrt_done;
    sts.out_free  = !out_valid_r || out_ready;
  end
endmodule
`default_nettype wire

[sv/grid_nearest_obstacle_search_core.sv]
// ---------------------------------------------------------------------------
// Grid nearest obstacle search core
// Occupancy map with nearest-obstacle window search around a world position.
// ---------------------------------------------------------------------------
// Channel  Dir  Transfer               Payload
// in_ch    in   valid & ready          mode, pixel_col/row, is_obstacle, query_x/y
// out_ch   out  valid & ready          status, distance, obstacle_x/y
// cfg_*    in   cfg_we                 cfg_index, cfg_wdata (no read-back)
//
// Reset starts a sweep that zeroes all MAP_DIM*MAP_DIM map entries, in_ch.ready low;
// config writes are taken throughout. A map write leaves the controller idle.
// A query: accept, index division (x, then y), check, scan of the (2r+1)^2 window
// (one map read a cycle), drain of the distance pipeline, root, result load.
// Outside-map queries skip scan and root, empty windows skip the root; a finished
// query waits only while the output register still holds an untaken result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_nearest_obstacle_search_core_assert.svh"
module grid_nearest_obstacle_search_core #(
  parameter int MAP_DIM    = gnos_pkg::MAP_DIM_DEF,
  parameter int MAX_RADIUS = gnos_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gnos_stream_if.sink                     in_ch,
  gnos_stream_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [gnos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnos_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  gnos_pkg::ctrl_cmd_t cmd;
  gnos_pkg::dp_sts_t   sts;
  gnos_pkg::in_item_t  in_item;
  gnos_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  assign in_item     = in_ch.payload;
  assign in_ch.ready = in_ready;

  // controller: clear sweep, item dispatch, query sequencing
  gnos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_item.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: map store, divider, scan pipeline, root, output register
  gnos_datapath #(
    .MAP_DIM    (MAP_DIM),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  // a new result never overwrites one still waiting
  `GNOS_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, (!out_ch.valid || out_ch.ready))
  // the root is only taken when an obstacle was found
  `GNOS_ASSERT_IMPL(a_root_found, clk, rst_n, cmd.sqrt_start, sts.found)
  // no scan for a position outside the map
  `GNOS_ASSERT_IMPL(a_scan_inside, clk, rst_n, cmd.scan_step, !sts.outside)
  // a transferred result drops unless a new one is loaded
  `GNOS_ASSERT_NEXT(a_out_drop, clk, rst_n, (out_ch.valid && out_ch.ready && !cmd.out_load), !out_ch.valid)
endmodule
`default_nettype wire
